>>> src/tzwm_pkg.sv
// ----------------------------------------------------------------------------
// tzwm_pkg
// Shared types, constants and span checks for the time zone window matcher.
// ----------------------------------------------------------------------------
package tzwm_pkg;

  localparam int unsigned ZONE_COUNT_DEF     = 32;
  localparam int unsigned SPANS_PER_ZONE_DEF = 4;

  localparam logic [6:0] NEVER_ID  = 7'd0;
  localparam logic [6:0] ALWAYS_ID = 7'd99;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [5:0] MAX_HOUR    = 6'd23;
  localparam logic [5:0] MAX_MINUTE  = 6'd59;
  localparam logic [5:0] END_OF_DAY  = 6'd24;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 8;

  // one stored span, start hour in the low bits
  typedef struct packed {
    logic [5:0] em;
    logic [5:0] eh;
    logic [5:0] sm;
    logic [5:0] sh;
  } span_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;    // write zero at clear pointer, advance it
    logic accept;    // input item taken this cycle
    logic rd_en;     // read next span of the captured zone
    logic load_out;  // latch result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;   // clear pointer at last entry
    logic span_last;  // span pointer at last span of zone
    logic tbl_query;  // incoming item is a query on a table zone
  } sts_t;

  function automatic logic span_null(input span_t s);
    return (s.sh == '0) && (s.sm == '0) && (s.eh == '0) && (s.em == '0);
  endfunction

  function automatic logic span_valid(input span_t s);
    logic ok;
    ok = 1'b1;
    if ((s.sh > MAX_HOUR) || (s.sm > MAX_MINUTE) || (s.em > MAX_MINUTE)) ok = 1'b0;
    if ((s.eh > MAX_HOUR) && ((s.eh != END_OF_DAY) || (s.em != '0))) ok = 1'b0;
    if (s.sh != s.eh) begin
      if (!(s.sh < s.eh)) ok = 1'b0;
    end else begin
      if (!(s.sm < s.em)) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic span_holds(input span_t s, input logic [5:0] h,
                                      input logic [5:0] m);
    logic hit;
    hit = 1'b1;
    if ((h < s.sh) || (h > s.eh)) hit = 1'b0;
    if ((h == s.sh) && (m < s.sm)) hit = 1'b0;
    if ((h == s.eh) && (m >= s.em)) hit = 1'b0;
    return hit;
  endfunction

endpackage

>>> src/time_zone_window_matcher_top.sv
// Sequence: a query on a table zone goes from accept through ST_READ, one span read
//   per span, then ST_DRAIN and ST_DONE; writes and queries on ids 0, 99 or illegal
//   ids go from accept straight to ST_DONE, which waits for a free output register.
// Flow: a new item is taken only in ST_IDLE; the single-port span table delivers one
//   span per cycle. Reset: the table is cleared one entry per cycle, every entry in
//   turn, with s_axis_tready held low.
// ----------------------------------------------------------------------------
// time_zone_window_matcher_top
// Zone table of start/end spans; writes store a span, queries test a time.
// ----------------------------------------------------------------------------
module time_zone_window_matcher_top #(
  parameter int unsigned ZONE_COUNT     = tzwm_pkg::ZONE_COUNT_DEF,
  parameter int unsigned SPANS_PER_ZONE = tzwm_pkg::SPANS_PER_ZONE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // zone_id[6:0], span_index[8:7], start_hour[14:9], start_minute[20:15],
  // end_hour[26:21], end_minute[32:27], now_hour[37:33], now_minute[43:38]
  input  logic [tzwm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode[0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // in_zone[0], id_ok[1], data_ok[2]
  output logic [tzwm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import tzwm_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] res;

  tzwm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  tzwm_dp #(
    .ZONE_COUNT     (ZONE_COUNT),
    .SPANS_PER_ZONE (SPANS_PER_ZONE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_o        (res)
  );

  assign m_axis_tdata = {(OUT_DATA_W - 3)'(0), res};

endmodule

>>> src/tzwm_ctrl.sv
// ----------------------------------------------------------------------------
// tzwm_ctrl
// Sequencer: table clear after reset, span reads for queries, output handoff.
// ----------------------------------------------------------------------------
module tzwm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  input  tzwm_pkg::sts_t sts_i,
  output tzwm_pkg::cmd_t cmd_o
);
  import tzwm_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d         = state_q;
    out_valid_d     = out_valid_q;
    cmd_o           = '0;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.tbl_query ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.span_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        // wait until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;

endmodule

>>> src/tzwm_dp.sv
// ----------------------------------------------------------------------------
// tzwm_dp
// Datapath: span table, item capture, span evaluation and result register.
// ----------------------------------------------------------------------------
module tzwm_dp #(
  parameter int unsigned ZONE_COUNT     = tzwm_pkg::ZONE_COUNT_DEF,
  parameter int unsigned SPANS_PER_ZONE = tzwm_pkg::SPANS_PER_ZONE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [tzwm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  tzwm_pkg::cmd_t                      cmd_i,
  output tzwm_pkg::sts_t                      sts_o,
  output logic [2:0]                          res_o
);
  import tzwm_pkg::*;

  localparam int unsigned ZONE_W = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int unsigned SPAN_W = (SPANS_PER_ZONE > 1) ? $clog2(SPANS_PER_ZONE) : 1;
  localparam int unsigned ADDR_W = ZONE_W + SPAN_W;
  localparam int unsigned DEPTH  = ZONE_COUNT * (1 << SPAN_W);

  localparam logic [6:0]        ZONE_LAST_ID = 7'(ZONE_COUNT);
  localparam logic [3:0]        SPAN_LIM     = 4'(SPANS_PER_ZONE);
  localparam logic [SPAN_W-1:0] SPAN_LAST    = SPAN_W'(SPANS_PER_ZONE - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST    = ADDR_W'(DEPTH - 1);

  // input fields
  logic [6:0] in_id;
  logic [1:0] in_idx;
  span_t      in_span;
  logic [4:0] in_nh;
  logic [5:0] in_nm;

  assign in_id      = s_axis_tdata[6:0];
  assign in_idx     = s_axis_tdata[8:7];
  assign in_span.sh = s_axis_tdata[14:9];
  assign in_span.sm = s_axis_tdata[20:15];
  assign in_span.eh = s_axis_tdata[26:21];
  assign in_span.em = s_axis_tdata[32:27];
  assign in_nh      = s_axis_tdata[37:33];
  assign in_nm      = s_axis_tdata[43:38];

  logic              in_tbl_id;
  logic              in_wr_en;
  logic [ZONE_W-1:0] in_zone;

  assign in_tbl_id = (in_id != NEVER_ID) && (in_id <= ZONE_LAST_ID);
  assign in_wr_en  = (s_axis_tuser == MODE_WRITE) && in_tbl_id && ({2'b00, in_idx} < SPAN_LIM);
  assign in_zone   = ZONE_W'(in_id - 7'd1);

  // captured item
  logic              mode_q;
  logic [6:0]        id_q;
  logic              tbl_id_q;
  logic              wr_span_ok_q;
  logic [ZONE_W-1:0] zone_q;
  logic [4:0]        nh_q;
  logic [5:0]        nm_q;

  // control registers
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [SPAN_W-1:0] span_cnt_q;
  logic              eval_q;
  logic              in_zone_q;
  logic              data_ok_q;

  // table
  span_t             mem [DEPTH];
  span_t             rd_q;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  span_t             mem_wdata;

  always_comb begin
    if (cmd_i.clr_en)      mem_addr = clr_cnt_q;
    else if (cmd_i.rd_en)  mem_addr = {zone_q, span_cnt_q};
    else                   mem_addr = {in_zone, SPAN_W'(in_idx)};
  end

  assign mem_we    = cmd_i.clr_en || (cmd_i.accept && in_wr_en);
  assign mem_wdata = cmd_i.clr_en ? span_t'('0) : in_span;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd_i.rd_en) rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q       <= s_axis_tuser;
      id_q         <= in_id;
      tbl_id_q     <= in_tbl_id;
      wr_span_ok_q <= span_null(in_span) || span_valid(in_span);
      zone_q       <= in_zone;
      nh_q         <= in_nh;
      nm_q         <= in_nm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      span_cnt_q <= '0;
      eval_q     <= 1'b0;
      in_zone_q  <= 1'b0;
      data_ok_q  <= 1'b1;
    end else begin
      eval_q <= cmd_i.rd_en;
      if (cmd_i.clr_en) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.accept) begin
        span_cnt_q <= '0;
        in_zone_q  <= 1'b0;
        data_ok_q  <= 1'b1;
      end else begin
        if (cmd_i.rd_en) span_cnt_q <= span_cnt_q + 1'b1;
        // evaluate the span read in the previous cycle
        if (eval_q) begin
          if (span_holds(rd_q, {1'b0, nh_q}, nm_q)) in_zone_q <= 1'b1;
          if (!span_null(rd_q) && !span_valid(rd_q)) data_ok_q <= 1'b0;
        end
      end
    end
  end

  // result: bit 0 in_zone, bit 1 id_ok, bit 2 data_ok
  logic [2:0] res_d;
  logic [2:0] res_q;

  always_comb begin
    res_d = 3'b000;
    if (mode_q == MODE_WRITE) begin
      res_d = {wr_span_ok_q, tbl_id_q, 1'b0};
    end else if (id_q == NEVER_ID) begin
      res_d = 3'b110;
    end else if (id_q == ALWAYS_ID) begin
      res_d = 3'b111;
    end else if (tbl_id_q) begin
      res_d = {data_ok_q, 1'b1, in_zone_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) res_q <= res_d;
  end

  assign res_o           = res_q;
  assign sts_o.clr_last  = (clr_cnt_q == ADDR_LAST);
  assign sts_o.span_last = (span_cnt_q == SPAN_LAST);
  assign sts_o.tbl_query = (s_axis_tuser == MODE_QUERY) && in_tbl_id;

endmodule
